// ----- hw/rtl/apq_pkg.sv -----
// Shared types and codes for the aging priority queue.
// No dependencies; imported by the top level and the port checker.
`default_nettype none

package apq_pkg;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_AGE    = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int unsigned ID_W   = 8;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CNT_W  = 5;

  // one queue slot as stored in the slot memory
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic              prio;
    logic [TIME_W-1:0] arrival;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [1:0]       status;
    logic [ID_W-1:0]  head_id;
    logic             head_priority;
    logic [CNT_W-1:0] promoted_count;
    logic [CNT_W-1:0] occupancy;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_KEY  = 4'b0010,
    S_WALK = 4'b0100,
    S_POP  = 4'b1000
  } state_t;

  // true when entry a must stand ahead of entry b
  function automatic logic goes_before(input entry_t a, input entry_t b);
    return (a.prio && !b.prio) || ((a.prio == b.prio) && (a.arrival < b.arrival));
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/apq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the queue slots of the aging priority queue.
`default_nettype none

module apq_ram #(
  parameter int unsigned WIDTH = 41,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/aging_priority_queue_top.sv -----
// Aging priority queue, top level. Uses apq_pkg and one apq_ram slot memory.
// An insert walks the new item toward the head past each entry it outranks; a pop reads the
// head; empty/full/idle report from S_IDLE; an aging sweep re-places each slot in turn.
// One item at a time; the slot memory's single read port paces every step.
// The result strobe (done) pulses one cycle; the receiver cannot stall it.
// Reset (rst, synchronous) empties the queue and sets age_threshold to 400; no memory clear.
`default_nettype none

module aging_priority_queue_top
  import apq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  operation,
  input  wire logic [7:0]  entry_id,
  input  wire logic        entry_priority,
  input  wire logic [31:0] arrival_time,
  input  wire logic [31:0] current_time,
  // result channel
  output logic             done,
  output logic [1:0]       status,
  output logic [7:0]       head_id,
  output logic             head_priority,
  output logic [4:0]       promoted_count,
  output logic [4:0]       occupancy,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  // The queue is a circular buffer in the slot memory: logical slot 0 (the head)
  // sits at physical address head, so a pop only advances head.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] l);
    logic [AW:0] sum;
    sum = {1'b0, hd} + (AW + 1)'(l[AW-1:0]);
    if (sum >= DEPTH_A) begin
      sum = sum - DEPTH_A;
    end
    return sum[AW-1:0];
  endfunction

  // clamp a count to the 5-bit result field
  function automatic logic [CNT_W-1:0] sat5(input logic [CW-1:0] v);
    if (32'(v) > 32'd31) begin
      return CNT_W'(31);
    end
    return CNT_W'(v);
  endfunction

  // report with the given status, no head data and the given occupancy
  function automatic result_t report(input logic [1:0] st, input logic [CW-1:0] cnt);
    return '{status: st, head_id: '0, head_priority: 1'b0, promoted_count: '0,
             occupancy: sat5(cnt)};
  endfunction

  state_t         state;
  logic [AW-1:0]  head;
  logic [CW-1:0]  fill;
  logic [CW-1:0]  idx_i;     // aging: logical slot whose entry is being re-placed
  logic [CW-1:0]  idx_j;     // hole position while walking toward the head
  logic [CW-1:0]  promoted;
  logic           aging;
  entry_t         key;       // entry being placed
  logic [31:0]    now_q;
  logic [31:0]    age_threshold;
  result_t        res;
  logic           res_valid;
  logic           res_valid_next;

  // slot memory port signals
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  entry_t         wr_data;
  logic [AW-1:0]  rd_addr;
  entry_t         rd_data;

  logic           walk_move;
  logic           aged;
  logic [31:0]    wait_ticks;

  apq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign done           = res_valid;
  assign status         = res.status;
  assign head_id        = res.head_id;
  assign head_priority  = res.head_priority;
  assign promoted_count = res.promoted_count;
  assign occupancy      = res.occupancy;

  // rd_data holds slot idx_j-1 during S_WALK; shift it back while the key beats it
  assign walk_move  = (idx_j != '0) && goes_before(key, rd_data);

  // promote a regular entry that has waited long enough; no wrap on the wait
  assign wait_ticks = now_q - rd_data.arrival;
  assign aged       = !rd_data.prio && (now_q >= rd_data.arrival) &&
                      (wait_ticks >= age_threshold);

  // Drive the slot memory. Each read is issued in the cycle before its use; a write
  // never hits the address read in the same cycle, so no forwarding is needed.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = phys(head, idx_j);
    wr_data = key;
    rd_addr = head;
    unique case (state)
      S_IDLE: begin
        if (start && (operation == OP_INSERT)) begin
          rd_addr = phys(head, fill - CW'(1));   // tail entry
        end
      end
      S_KEY: begin
        rd_addr = phys(head, idx_i - CW'(1));   // neighbor ahead of the key
      end
      S_WALK: begin
        wr_en = 1'b1;
        if (walk_move) begin
          wr_data = rd_data;
          rd_addr = phys(head, idx_j - CW'(2));
        end else begin
          wr_data = key;
          rd_addr = phys(head, idx_i + CW'(1));  // next key of an aging sweep
        end
      end
      S_POP: begin
        rd_addr = head;
      end
      default: begin
        rd_addr = head;
      end
    endcase
  end

  // raise the result strobe after the cycle that finishes an item
  always_comb begin
    res_valid_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          case (operation)
            OP_INSERT: res_valid_next = (fill == DEPTH_C);
            OP_POP:    res_valid_next = (fill == '0);
            OP_AGE:    res_valid_next = (fill == '0);
            default:   res_valid_next = 1'b1;
          endcase
        end
      end
      S_WALK: begin
        res_valid_next = !walk_move && (!aging || ((idx_i + CW'(1)) >= fill));
      end
      S_POP: begin
        res_valid_next = 1'b1;
      end
      default: begin
        res_valid_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      head          <= '0;
      fill          <= '0;
      res_valid     <= 1'b0;
      age_threshold <= 32'd400;
    end else begin
      res_valid <= res_valid_next;
      if (cfg_valid && cfg_ready) begin
        age_threshold <= cfg_data;
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            // default report: ok, no data, occupancy unchanged
            case (operation)
              OP_INSERT: begin
                if (fill == DEPTH_C) begin
                  res <= report(ST_FULL, fill);
                end else begin
                  res   <= report(ST_OK, fill);
                  key   <= '{id: entry_id, prio: entry_priority, arrival: arrival_time};
                  idx_j <= fill;
                  aging <= 1'b0;
                  state <= S_WALK;
                end
              end
              OP_POP: begin
                if (fill == '0) begin
                  res <= report(ST_EMPTY, fill);
                end else begin
                  state <= S_POP;
                end
              end
              OP_AGE: begin
                res      <= report(ST_OK, fill);
                now_q    <= current_time;
                idx_i    <= '0;
                promoted <= '0;
                aging    <= 1'b1;
                if (fill != '0) begin
                  state <= S_KEY;
                end
              end
              default: begin
                res <= report(ST_OK, fill);
              end
            endcase
          end
        end

        S_KEY: begin
          // take slot idx_i as the key, promoting it if it has aged
          key      <= '{id: rd_data.id, prio: rd_data.prio | aged, arrival: rd_data.arrival};
          promoted <= promoted + CW'(aged);
          idx_j    <= idx_i;
          state    <= S_WALK;
        end

        S_WALK: begin
          if (walk_move) begin
            idx_j <= idx_j - CW'(1);
          end else if (aging) begin
            if ((idx_i + CW'(1)) < fill) begin
              idx_i <= idx_i + CW'(1);
              state <= S_KEY;
            end else begin
              res.promoted_count <= sat5(promoted);
              state              <= S_IDLE;
            end
          end else begin
            fill          <= fill + CW'(1);
            res.occupancy <= sat5(fill + CW'(1));
            state         <= S_IDLE;
          end
        end

        S_POP: begin
          // hand out the head and advance it
          res   <= '{status: ST_OK, head_id: rd_data.id, head_priority: rd_data.prio,
                     promoted_count: '0, occupancy: sat5(fill - CW'(1))};
          head  <= phys(head, CW'(1));
          fill  <= fill - CW'(1);
          state <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/apq_checker.sv -----
// Port-level checker for the aging priority queue, bound to the top level.
// Depends on apq_pkg for the status codes.
`default_nettype none

module apq_checker
  import apq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [1:0]  status,
  input wire logic [7:0]  head_id,
  input wire logic [4:0]  promoted_count,
  input wire logic [4:0]  occupancy
);

  localparam int unsigned MAX_OCC = (QUEUE_DEPTH > 31) ? 31 : QUEUE_DEPTH;

  // an accepted item either starts work or reports in the next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted item neither started nor reported");

  // a result is only shown once the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // full report only at capacity
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_FULL) |-> (32'(occupancy) == MAX_OCC) && (promoted_count == '0))
    else $error("full status with wrong occupancy");

  // empty report only with nothing held and no head data
  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_EMPTY) |-> (occupancy == '0) && (head_id == '0))
    else $error("empty status with entries held");

  // occupancy bounded, promotions never exceed holdings
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(occupancy) <= MAX_OCC) && (promoted_count <= occupancy))
    else $error("occupancy or promotion count out of range");

endmodule

bind aging_priority_queue_top apq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_apq_checker (.*);

`default_nettype wire

// ----- dv/aging_priority_queue_top_tb.sv -----
// Self-checking testbench for aging_priority_queue_top: insert, pop and aging
// commands checked against a shadow copy of the sorted queue kept in the bench.
// Depends on apq_pkg and the aging_priority_queue_top RTL only.

module aging_priority_queue_top_tb;
  import apq_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam logic [1:0] OP_NONE = 2'd3;         // unused command code
  localparam logic [31:0] RESET_THRESHOLD = 32'd400;
  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 200;    // longer than the slowest sweep
  localparam int unsigned MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] operation = OP_INSERT;
  logic [7:0] entry_id = '0;
  logic entry_priority = 1'b0;
  logic [31:0] arrival_time = '0;
  logic [31:0] current_time = '0;
  logic done;
  logic [1:0] status;
  logic [7:0] head_id;
  logic head_priority;
  logic [4:0] promoted_count;
  logic [4:0] occupancy;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  // shadow of the queue contents, kept in queue order, slot 0 is the head
  entry_t shadow_slots [DEPTH];
  int unsigned shadow_fill = 0;
  logic [31:0] shadow_threshold = RESET_THRESHOLD;

  result_t pending_outcomes [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_pct = 0;
  logic [31:0] tick;

  aging_priority_queue_top #(
    .QUEUE_DEPTH(DEPTH)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .entry_id      (entry_id),
    .entry_priority(entry_priority),
    .arrival_time  (arrival_time),
    .current_time  (current_time),
    .done          (done),
    .status        (status),
    .head_id       (head_id),
    .head_priority (head_priority),
    .promoted_count(promoted_count),
    .occupancy     (occupancy),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  // VIP first, then earlier arrival; equal keys keep their current order
  function automatic bit ranks_ahead(entry_t a, entry_t b);
    return (a.prio && !b.prio) || (a.prio == b.prio && a.arrival < b.arrival);
  endfunction

  // Apply one command to the shadow queue and return the result it must give.
  function automatic result_t predict_outcome(logic [1:0] op_code, entry_t item,
                                              logic [31:0] sweep_time);
    result_t res;
    int unsigned pos;
    int unsigned promoted;
    int unsigned i;
    entry_t key;
    res = '0;
    case (op_code)
      OP_INSERT: begin
        if (shadow_fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // walk the new entry forward past everything it outranks
          pos = shadow_fill;
          while (pos > 0 && ranks_ahead(item, shadow_slots[pos-1])) begin
            shadow_slots[pos] = shadow_slots[pos-1];
            pos--;
          end
          shadow_slots[pos] = item;
          shadow_fill++;
        end
      end
      OP_POP: begin
        if (shadow_fill == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.head_id = shadow_slots[0].id;
          res.head_priority = shadow_slots[0].prio;
          for (i = 0; i + 1 < shadow_fill; i++) shadow_slots[i] = shadow_slots[i+1];
          shadow_fill--;
        end
      end
      OP_AGE: begin
        promoted = 0;
        // an arrival after the sweep time has not waited at all
        for (i = 0; i < shadow_fill; i++) begin
          if (!shadow_slots[i].prio && sweep_time >= shadow_slots[i].arrival &&
              sweep_time - shadow_slots[i].arrival >= shadow_threshold) begin
            shadow_slots[i].prio = 1'b1;
            promoted++;
          end
        end
        // stable re-sort by insertion
        for (i = 1; i < shadow_fill; i++) begin
          key = shadow_slots[i];
          pos = i;
          while (pos > 0 && ranks_ahead(key, shadow_slots[pos-1])) begin
            shadow_slots[pos] = shadow_slots[pos-1];
            pos--;
          end
          shadow_slots[pos] = key;
        end
        res.promoted_count = CNT_W'(promoted);
      end
      default: begin
      end
    endcase
    res.occupancy = CNT_W'(shadow_fill);
    return res;
  endfunction

  function automatic string describe(result_t r);
    return $sformatf("status %0d id %0d prio %0d promoted %0d occupancy %0d",
                     r.status, r.head_id, r.head_priority, r.promoted_count, r.occupancy);
  endfunction

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR at cycle %0d: %s", cycle_count, msg);
  endtask

  // Compare every strobed result with the oldest outstanding prediction.
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && done) begin
      got = {status, head_id, head_priority, promoted_count, occupancy};
      if (pending_outcomes.size() == 0) begin
        flag_error({"result with nothing outstanding: ", describe(got)});
      end else begin
        want = pending_outcomes.pop_front();
        if (got !== want)
          flag_error({"expected ", describe(want), ", got ", describe(got)});
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("aging_priority_queue_top_tb: errors");
      $finish;
    end
  end

  // Drop start for a number of cycles.
  task automatic hold_off(int unsigned cycles);
    repeat (cycles) @(negedge clk) start <= 1'b0;
  endtask

  // Present one item, wait for the edge that takes it, then record its prediction.
  task automatic send_item(logic [1:0] op_code, logic [7:0] new_id, logic new_prio,
                           logic [31:0] new_arrival, logic [31:0] sweep_time);
    entry_t item;
    item = '{id: new_id, prio: new_prio, arrival: new_arrival};
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) hold_off($urandom_range(1, 10));
    @(negedge clk);
    start <= 1'b1;
    operation <= op_code;
    entry_id <= new_id;
    entry_priority <= new_prio;
    arrival_time <= new_arrival;
    current_time <= sweep_time;
    do @(posedge clk); while (busy);
    pending_outcomes.push_back(predict_outcome(op_code, item, sweep_time));
  endtask

  // Stop issuing and wait until every result is back and the block is idle.
  task automatic settle();
    @(negedge clk) start <= 1'b0;
    do @(posedge clk); while (pending_outcomes.size() != 0 || busy);
  endtask

  task automatic write_threshold(logic [31:0] value);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    shadow_threshold = value;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // Pop, sweep and the unused code on an empty queue.
  task automatic test_empty_queue();
    send_item(OP_POP, 8'hFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_NONE, 8'hA5, 1'b1, 32'h1234_5678, 32'h8765_4321);
    send_item(OP_AGE, 8'h00, 1'b0, 32'h0, 32'hFFFF_FFFF);
  endtask

  // The threshold after reset promotes at a wait of 400 ticks, not 399.
  task automatic test_reset_threshold();
    send_item(OP_INSERT, 8'h00, 1'b0, 32'd100, 32'd0);
    send_item(OP_INSERT, 8'hFF, 1'b1, 32'hFFFF_FFFF, 32'd0);
    send_item(OP_AGE, 8'h00, 1'b0, 32'd0, 32'd499);
    send_item(OP_AGE, 8'h00, 1'b0, 32'd0, 32'd500);
    send_item(OP_POP, 8'h00, 1'b0, 32'd0, 32'd0);
    send_item(OP_POP, 8'h00, 1'b0, 32'd0, 32'd0);
  endtask

  // Equal keys queue behind earlier entries; VIP and earlier arrival go first.
  task automatic test_tie_order();
    send_item(OP_INSERT, 8'd1, 1'b0, 32'd50, 32'd0);
    send_item(OP_INSERT, 8'd2, 1'b0, 32'd50, 32'd0);
    send_item(OP_INSERT, 8'd3, 1'b1, 32'd50, 32'd0);
    send_item(OP_INSERT, 8'd4, 1'b0, 32'd49, 32'd0);
    repeat (4) send_item(OP_POP, 8'd0, 1'b0, 32'd0, 32'd0);
  endtask

  // Threshold 0 still skips arrivals in the future; all-ones needs the full span.
  task automatic test_threshold_extremes();
    write_threshold(32'h0);
    send_item(OP_INSERT, 8'h10, 1'b0, 32'd1000, 32'd0);
    send_item(OP_INSERT, 8'h20, 1'b0, 32'd900, 32'd0);
    send_item(OP_AGE, 8'h00, 1'b0, 32'd0, 32'd999);
    send_item(OP_AGE, 8'h00, 1'b0, 32'd0, 32'd1000);
    write_threshold(32'hFFFF_FFFF);
    send_item(OP_INSERT, 8'h30, 1'b0, 32'h0, 32'd0);
    send_item(OP_AGE, 8'h00, 1'b0, 32'd0, 32'hFFFF_FFFE);
    send_item(OP_AGE, 8'h00, 1'b0, 32'd0, 32'hFFFF_FFFF);
  endtask

  // One random item: style 0 insert, 1 pop, otherwise a weighted mix.
  task automatic send_random(int unsigned style);
    logic [1:0] op_code;
    logic [31:0] new_arrival;
    logic [31:0] sweep_time;
    int unsigned roll;
    roll = $urandom_range(99);
    if (style == 0) op_code = OP_INSERT;
    else if (style == 1) op_code = OP_POP;
    else if (roll < 40) op_code = OP_INSERT;
    else if (roll < 68) op_code = OP_POP;
    else if (roll < 95) op_code = OP_AGE;
    else op_code = OP_NONE;
    // advance a local clock; arrivals trail it, sweeps lead it
    tick = tick + $urandom_range(0, 8);
    new_arrival = ($urandom_range(7) == 0) ? $urandom : tick - $urandom_range(0, 40);
    sweep_time = ($urandom_range(7) == 0) ? $urandom : tick + $urandom_range(0, 250);
    send_item(op_code, 8'($urandom), $urandom_range(2) == 0, new_arrival, sweep_time);
  endtask

  // Bursts of inserts reach a full queue, bursts of pops an empty one,
  // mixed stretches exercise the sweep in between.
  task automatic test_random_traffic(int unsigned item_goal, logic [31:0] threshold,
                                     bit with_gaps);
    int unsigned sent;
    int unsigned burst;
    int unsigned style;
    int unsigned pick;
    write_threshold(threshold);
    sent = 0;
    while (sent < item_goal) begin
      gap_pct = (with_gaps && $urandom_range(1) == 1) ? 30 : 0;
      pick = $urandom_range(99);
      if (pick < 15) begin
        style = 0;
        burst = $urandom_range(1, 20);
      end else if (pick < 25) begin
        style = 1;
        burst = $urandom_range(1, 20);
      end else begin
        style = 2;
        burst = $urandom_range(1, 8);
      end
      repeat (burst) begin
        send_random(style);
        sent++;
      end
    end
    gap_pct = 0;
  endtask

  initial begin
    tick = $urandom;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_reset_threshold();
    test_tie_order();
    test_threshold_extremes();
    test_random_traffic(400, $urandom_range(20, 200), 1'b1);
    test_random_traffic(400, 32'h0, 1'b1);
    test_random_traffic(400, 32'hFFFF_FFFF, 1'b1);
    test_random_traffic(400, RESET_THRESHOLD, 1'b0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_outcomes.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_outcomes.size()));
    if (error_count == 0) begin
      $display("aging_priority_queue_top_tb: clean");
    end else begin
      $display("aging_priority_queue_top_tb: errors");
    end
    $finish;
  end

endmodule
